[rtl/core/tsfs_pkg.sv]
`default_nettype none
package tsfs_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIENT = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG   = 3'd6;

    localparam int SCR_BITS = 10;

    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_MOVE = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    // job kinds passed from front to back
    typedef enum logic [1:0] {
        JOB_RELEASE = 2'd0,
        JOB_FRAME   = 2'd1
    } job_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE   = 3'd0,
        BK_SCAN   = 3'd1,
        BK_SUM    = 3'd2,
        BK_MEAN   = 3'd3,
        BK_MUL    = 3'd4,
        BK_DIV    = 3'd5,
        BK_EMIT   = 3'd6
    } back_state_t;

endpackage
`default_nettype wire

[rtl/core/tsfs_front.sv]
`default_nettype none
module tsfs_front
    import tsfs_pkg::*;
#(
    parameter int FRAME_SAMPLES = 5,
    parameter int RAW_BITS = 12
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [RAW_BITS-1:0] raw_x,
    input  wire logic [RAW_BITS-1:0] raw_y,
    input  wire logic                pen_down,
    // job to back part
    output logic                     job_valid,
    input  wire logic                job_stall,
    output job_kind_t                job_kind,
    output logic [FRAME_SAMPLES*RAW_BITS-1:0] job_xs,
    output logic [FRAME_SAMPLES*RAW_BITS-1:0] job_ys
);

    localparam int CNT_BITS = $clog2(FRAME_SAMPLES + 1);
    localparam int IDX_BITS = $clog2(FRAME_SAMPLES);

    logic [RAW_BITS-1:0] sx_reg [FRAME_SAMPLES];
    logic [RAW_BITS-1:0] sy_reg [FRAME_SAMPLES];
    logic [CNT_BITS-1:0] cnt_reg;

    // two-entry job queue
    job_kind_t q_kind_reg [2];
    logic [FRAME_SAMPLES*RAW_BITS-1:0] q_xs_reg [2];
    logic [FRAME_SAMPLES*RAW_BITS-1:0] q_ys_reg [2];
    logic [1:0] q_cnt_reg;
    logic q_rd_reg, q_wr_reg;

    logic acc, push, pop, last;
    logic [FRAME_SAMPLES*RAW_BITS-1:0] fx, fy;

    assign in_stall = (q_cnt_reg == 2'd2);
    assign acc  = in_valid && !in_stall;
    assign last = (cnt_reg == CNT_BITS'(FRAME_SAMPLES - 1));
    assign push = acc && (!pen_down || last);
    assign job_valid = (q_cnt_reg != 2'd0);
    assign pop  = job_valid && !job_stall;
    assign job_kind = q_kind_reg[q_rd_reg];
    assign job_xs   = q_xs_reg[q_rd_reg];
    assign job_ys   = q_ys_reg[q_rd_reg];

    // frame with the newest sample inserted
    always_comb
    begin
        for (int i = 0; i < FRAME_SAMPLES; i++)
        begin
            fx[i*RAW_BITS +: RAW_BITS] = sx_reg[i];
            fy[i*RAW_BITS +: RAW_BITS] = sy_reg[i];
        end
        fx[(FRAME_SAMPLES-1)*RAW_BITS +: RAW_BITS] = raw_x;
        fy[(FRAME_SAMPLES-1)*RAW_BITS +: RAW_BITS] = raw_y;
    end

    // sample gathering
    always_ff @(posedge clk)
    begin
        if (acc && pen_down && !last)
        begin
            sx_reg[cnt_reg[IDX_BITS-1:0]] <= raw_x;
            sy_reg[cnt_reg[IDX_BITS-1:0]] <= raw_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (acc)
        begin
            if (!pen_down || last)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_kind_reg[q_wr_reg] <= pen_down ? JOB_FRAME : JOB_RELEASE;
            q_xs_reg[q_wr_reg]   <= fx;
            q_ys_reg[q_wr_reg]   <= fy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            q_rd_reg  <= 1'b0;
            q_wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                q_wr_reg <= ~q_wr_reg;
            if (pop)
                q_rd_reg <= ~q_rd_reg;
            case ({push, pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + 2'd1;
                2'b01:   q_cnt_reg <= q_cnt_reg - 2'd1;
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/core/tsfs_back.sv]
`default_nettype none
module tsfs_back
    import tsfs_pkg::*;
#(
    parameter int FRAME_SAMPLES = 5,
    parameter int RAW_BITS = 12
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                job_valid,
    output logic                     job_stall,
    input  wire job_kind_t           job_kind,
    input  wire logic [FRAME_SAMPLES*RAW_BITS-1:0] job_xs,
    input  wire logic [FRAME_SAMPLES*RAW_BITS-1:0] job_ys,
    input  wire logic [RAW_BITS-1:0] x_low,
    input  wire logic [RAW_BITS-1:0] x_high,
    input  wire logic [RAW_BITS-1:0] y_low,
    input  wire logic [RAW_BITS-1:0] y_high,
    input  wire logic                orient,
    input  wire logic [SCR_BITS-1:0] short_max,
    input  wire logic [SCR_BITS-1:0] long_max,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               event_kind,
    output logic [SCR_BITS-1:0]      screen_x,
    output logic [SCR_BITS-1:0]      screen_y
);

    localparam int IDX_BITS = $clog2(FRAME_SAMPLES);
    localparam int SUM_BITS = RAW_BITS + $clog2(FRAME_SAMPLES + 1);
    localparam int PROD_BITS = RAW_BITS + SCR_BITS;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);
    localparam int MEAN_DIV = FRAME_SAMPLES - 2;
    // reciprocal of the trimmed sample count, exact over the whole sum range
    localparam int REC_SHIFT = SUM_BITS + $clog2(MEAN_DIV);
    localparam int REC_BITS = REC_SHIFT + 1;
    localparam int MPROD_BITS = SUM_BITS + REC_BITS;
    localparam logic [REC_BITS-1:0] REC_MUL =
        REC_BITS'(((64'd1 << REC_SHIFT) + 64'(MEAN_DIV - 1)) / 64'(MEAN_DIV));

    back_state_t state_reg, state_next;

    logic [FRAME_SAMPLES*RAW_BITS-1:0] xs_reg, ys_reg;
    job_kind_t           kind_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic [RAW_BITS:0]   xlo_reg, xhi_reg, ylo_reg, yhi_reg;
    logic [IDX_BITS-1:0] xilo_reg, xihi_reg, yilo_reg, yihi_reg;
    logic [SUM_BITS-1:0] xsum_reg, ysum_reg;
    logic [RAW_BITS-1:0] fx_reg, fy_reg;
    // two scale lanes: a is screen_x, b is screen_y
    logic [PROD_BITS-1:0] pa_reg, pb_reg, qa_reg, qb_reg;
    logic [RAW_BITS:0]    ra_reg, rb_reg;
    logic [RAW_BITS-1:0]  da_reg, db_reg;
    logic                 za_reg, zb_reg;
    logic [DIV_CNT_BITS-1:0] dcnt_reg;
    logic                 touching_reg;
    logic [SCR_BITS-1:0]  lx_reg, ly_reg;
    logic                 ov_reg;
    logic [1:0]           ek_reg;
    logic [SCR_BITS-1:0]  ox_reg, oy_reg;

    logic [RAW_BITS-1:0] vx, vy;
    logic last_idx;
    logic [RAW_BITS-1:0] cx, cy, xo, yo;
    logic x_zero, y_zero;
    logic [RAW_BITS-1:0] xspan, yspan;
    logic [RAW_BITS:0] ra_try, rb_try;
    logic [SCR_BITS-1:0] sx, sy;
    logic [MPROD_BITS-1:0] xmp, ymp;
    logic emit_go, emit_ev;

    assign vx = xs_reg[idx_reg*RAW_BITS +: RAW_BITS];
    assign vy = ys_reg[idx_reg*RAW_BITS +: RAW_BITS];
    assign last_idx = (idx_reg == IDX_BITS'(FRAME_SAMPLES - 1));
    assign job_stall = (state_reg != BK_IDLE);
    assign out_valid = ov_reg;
    assign event_kind = ek_reg;
    assign screen_x = ox_reg;
    assign screen_y = oy_reg;

    // clamp and offset of the filtered values
    always_comb
    begin
        x_zero = (x_high <= x_low);
        y_zero = (y_high <= y_low);
        xspan = x_high - x_low;
        yspan = y_high - y_low;
        cx = (fx_reg > x_high) ? x_high : ((fx_reg < x_low) ? x_low : fx_reg);
        cy = (fy_reg > y_high) ? y_high : ((fy_reg < y_low) ? y_low : fy_reg);
        xo = cx - x_low;
        yo = cy - y_low;
    end

    // trimmed sum times reciprocal
    always_comb
    begin
        xmp = MPROD_BITS'(xsum_reg) * MPROD_BITS'(REC_MUL);
        ymp = MPROD_BITS'(ysum_reg) * MPROD_BITS'(REC_MUL);
    end

    // restoring divide step
    always_comb
    begin
        ra_try = {ra_reg[RAW_BITS-1:0], pa_reg[PROD_BITS-1]};
        rb_try = {rb_reg[RAW_BITS-1:0], pb_reg[PROD_BITS-1]};
    end

    // final screen coordinates
    always_comb
    begin
        sx = za_reg ? '0 : qa_reg[SCR_BITS-1:0];
        if (zb_reg)
            sy = '0;
        else if (!orient)
            sy = long_max - qb_reg[SCR_BITS-1:0];
        else
            sy = qb_reg[SCR_BITS-1:0];
    end

    // whether the job gives an event
    always_comb
    begin
        emit_go = (state_reg == BK_EMIT) && (!ov_reg || !out_stall);
        if (kind_reg == JOB_RELEASE)
            emit_ev = touching_reg;
        else
            emit_ev = !(touching_reg && sx == lx_reg && sy == ly_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    if (job_kind == JOB_FRAME)
                        state_next = BK_SCAN;
                    else
                        state_next = BK_EMIT;
                end
            end
            BK_SCAN: if (last_idx) state_next = BK_SUM;
            BK_SUM:  if (last_idx) state_next = BK_MEAN;
            BK_MEAN: state_next = BK_MUL;
            BK_MUL:  state_next = BK_DIV;
            BK_DIV:  if (dcnt_reg == DIV_CNT_BITS'(PROD_BITS - 1)) state_next = BK_EMIT;
            BK_EMIT: if (!ov_reg || !out_stall) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                xs_reg <= job_xs;
                ys_reg <= job_ys;
                kind_reg <= job_kind;
                idx_reg <= '0;
                xlo_reg <= (RAW_BITS+1)'(1) << RAW_BITS;
                ylo_reg <= (RAW_BITS+1)'(1) << RAW_BITS;
                xhi_reg <= '0;
                yhi_reg <= '0;
                xilo_reg <= '0;
                xihi_reg <= '0;
                yilo_reg <= '0;
                yihi_reg <= '0;
                xsum_reg <= '0;
                ysum_reg <= '0;
            end
            BK_SCAN:
            begin
                if ({1'b0, vx} < xlo_reg) begin xlo_reg <= {1'b0, vx}; xilo_reg <= idx_reg; end
                if ({1'b0, vx} > xhi_reg) begin xhi_reg <= {1'b0, vx}; xihi_reg <= idx_reg; end
                if ({1'b0, vy} < ylo_reg) begin ylo_reg <= {1'b0, vy}; yilo_reg <= idx_reg; end
                if ({1'b0, vy} > yhi_reg) begin yhi_reg <= {1'b0, vy}; yihi_reg <= idx_reg; end
                idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
            end
            BK_SUM:
            begin
                if (idx_reg != xilo_reg && idx_reg != xihi_reg)
                    xsum_reg <= xsum_reg + SUM_BITS'(vx);
                if (idx_reg != yilo_reg && idx_reg != yihi_reg)
                    ysum_reg <= ysum_reg + SUM_BITS'(vy);
                idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
            end
            BK_MEAN:
            begin
                // floor mean by reciprocal multiply and shift
                fx_reg <= (xilo_reg == xihi_reg) ? xlo_reg[RAW_BITS-1:0]
                                                 : RAW_BITS'(xmp >> REC_SHIFT);
                fy_reg <= (yilo_reg == yihi_reg) ? ylo_reg[RAW_BITS-1:0]
                                                 : RAW_BITS'(ymp >> REC_SHIFT);
            end
            BK_MUL:
            begin
                if (!orient)
                begin
                    pa_reg <= PROD_BITS'(xo * short_max);
                    da_reg <= xspan;
                    za_reg <= x_zero;
                    pb_reg <= PROD_BITS'(yo * long_max);
                    db_reg <= yspan;
                    zb_reg <= y_zero;
                end
                else
                begin
                    pa_reg <= PROD_BITS'(yo * long_max);
                    da_reg <= yspan;
                    za_reg <= y_zero;
                    pb_reg <= PROD_BITS'(xo * short_max);
                    db_reg <= xspan;
                    zb_reg <= x_zero;
                end
                ra_reg <= '0;
                rb_reg <= '0;
                qa_reg <= '0;
                qb_reg <= '0;
                dcnt_reg <= '0;
            end
            BK_DIV:
            begin
                pa_reg <= pa_reg << 1;
                pb_reg <= pb_reg << 1;
                if (ra_try >= {1'b0, da_reg})
                begin
                    ra_reg <= ra_try - {1'b0, da_reg};
                    qa_reg <= {qa_reg[PROD_BITS-2:0], 1'b1};
                end
                else
                begin
                    ra_reg <= ra_try;
                    qa_reg <= {qa_reg[PROD_BITS-2:0], 1'b0};
                end
                if (rb_try >= {1'b0, db_reg})
                begin
                    rb_reg <= rb_try - {1'b0, db_reg};
                    qb_reg <= {qb_reg[PROD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rb_reg <= rb_try;
                    qb_reg <= {qb_reg[PROD_BITS-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // event decision and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            touching_reg <= 1'b0;
            lx_reg <= '0;
            ly_reg <= '0;
            ek_reg <= EV_DOWN;
            ox_reg <= '0;
            oy_reg <= '0;
        end
        else if (emit_go && emit_ev)
        begin
            ov_reg <= 1'b1;
            if (kind_reg == JOB_RELEASE)
            begin
                ek_reg <= EV_UP;
                ox_reg <= lx_reg;
                oy_reg <= ly_reg;
                touching_reg <= 1'b0;
            end
            else
            begin
                ek_reg <= touching_reg ? EV_MOVE : EV_DOWN;
                ox_reg <= sx;
                oy_reg <= sy;
                lx_reg <= sx;
                ly_reg <= sy;
                touching_reg <= 1'b1;
            end
        end
        else if (ov_reg && !out_stall)
        begin
            ov_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[rtl/core/touch_sample_filter_scaler_core.sv]
// touch sample filter and scaler
// input channel: in_valid / in_stall with raw_x, raw_y, pen_down; one beat per sample
// output channel: out_valid / out_stall with event_kind, screen_x, screen_y
// config channel: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data; write only
// while idle
// the front gathers pen-down samples into a frame; a full frame or a pen-up
// beat is put in a two-entry job queue, other samples give no event
// the back takes one job at a time: a min/max scan of the frame, the trimmed
// sum, mean and multiply, the bit-serial divider and emit, in that order;
// a pen-up job goes straight from idle to emit
// the queue lets the front accept samples while the back works, so samples
// within a frame go one per cycle while the queue is not full
// reset clears counters, queue, touch state and last point and loads the
// calibration defaults
// while out_stall is high the event is held and the back waits in its emit state; once the
// queue is full in_stall rises
`default_nettype none
module touch_sample_filter_scaler_core
    import tsfs_pkg::*;
#(
    parameter int FRAME_SAMPLES = 5,
    parameter int RAW_BITS = 12
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [RAW_BITS-1:0]     raw_x,
    input  wire logic [RAW_BITS-1:0]     raw_y,
    input  wire logic                    pen_down,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   event_kind,
    output logic [SCR_BITS-1:0]          screen_x,
    output logic [SCR_BITS-1:0]          screen_y,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [RAW_BITS-1:0]     cfg_data
);

    logic [RAW_BITS-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic                orient_reg;
    logic [SCR_BITS-1:0] short_reg, long_reg;

    logic job_valid, job_stall;
    job_kind_t job_kind;
    logic [FRAME_SAMPLES*RAW_BITS-1:0] job_xs, job_ys;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= RAW_BITS'(230);
            x_high_reg <= RAW_BITS'(3820);
            y_low_reg  <= RAW_BITS'(340);
            y_high_reg <= RAW_BITS'(3920);
            orient_reg <= 1'b0;
            short_reg  <= SCR_BITS'(239);
            long_reg   <= SCR_BITS'(319);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_X_LOW:  x_low_reg  <= cfg_data;
                REG_X_HIGH: x_high_reg <= cfg_data;
                REG_Y_LOW:  y_low_reg  <= cfg_data;
                REG_Y_HIGH: y_high_reg <= cfg_data;
                REG_ORIENT: orient_reg <= cfg_data[0];
                REG_SHORT:  short_reg  <= SCR_BITS'(cfg_data);
                REG_LONG:   long_reg   <= SCR_BITS'(cfg_data);
                default:    ;
            endcase
        end
    end

    tsfs_front #(.FRAME_SAMPLES(FRAME_SAMPLES), .RAW_BITS(RAW_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .raw_x(raw_x), .raw_y(raw_y), .pen_down(pen_down),
        .job_valid(job_valid), .job_stall(job_stall), .job_kind(job_kind),
        .job_xs(job_xs), .job_ys(job_ys)
    );

    tsfs_back #(.FRAME_SAMPLES(FRAME_SAMPLES), .RAW_BITS(RAW_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_stall(job_stall), .job_kind(job_kind),
        .job_xs(job_xs), .job_ys(job_ys),
        .x_low(x_low_reg), .x_high(x_high_reg), .y_low(y_low_reg), .y_high(y_high_reg),
        .orient(orient_reg), .short_max(short_reg), .long_max(long_reg),
        .out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
        .screen_x(screen_x), .screen_y(screen_y)
    );

endmodule
`default_nettype wire

[rtl/core/tsfs_checker.sv]
`default_nettype none
module tsfs_checker
    import tsfs_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] event_kind
);

    // a held event stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("event dropped while stalled");

    // held event kind does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(event_kind))
        else $error("event kind changed while stalled");

    // only three event codes exist
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == EV_DOWN || event_kind == EV_MOVE || event_kind == EV_UP))
        else $error("bad event kind");

    // no event in the first cycle after reset release
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("event right after reset");

endmodule

bind touch_sample_filter_scaler_core tsfs_checker u_tsfs_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind)
);
`default_nettype wire
